/* sv/tsrw_pkg.sv */
// Shared constants and helpers for the timestamp reorder window.
package tsrw_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STAMP_W  = 64;
  localparam int THR_W    = 6;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [THR_W-1:0] THR_RESET = 6'd18;

  // Register index, taken from paddr[2]
  localparam logic REG_FILL_THRESHOLD = 1'b0;

  // Threshold as used: zero acts as one, values above capacity saturate
  function automatic logic [CNT_W-1:0] eff_threshold(input logic [THR_W-1:0] thr);
    logic [CNT_W-1:0] res;
    if (thr == '0) begin
      res = CNT_W'(1);
    end else if (int'(thr) > CAPACITY) begin
      res = CNT_W'(CAPACITY);
    end else begin
      res = CNT_W'(thr);
    end
    return res;
  endfunction

endpackage

/* sv/timestamp_reorder_window_core.sv */
// Reorder window: holds timestamps in arrival order, releases the smallest.
// Throughput: one item per cycle when nothing is released; an item that causes a release
// keeps the input stalled through the scan, the release and the shift, plus any output
// stall, as every sweep goes through the single memory read port.
// Reset (synchronous, rst high): window empty, threshold 18, last released zero; no clear.
module timestamp_reorder_window_core
  import tsrw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [STAMP_W-1:0]  arriving_timestamp,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STAMP_W-1:0]  released_timestamp,
  output logic                went_backwards,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_SHIFT = 2'd3;

  logic [1:0]         state;
  logic [CNT_W-1:0]   count;
  logic [THR_W-1:0]   fill_threshold;
  logic [STAMP_W-1:0] last_released;

  // sweep index and the read in flight
  logic [CNT_W-1:0]   idx;
  logic               pend_vld;
  logic [ADDR_W-1:0]  pend_pos;

  logic [STAMP_W-1:0] best_val;
  logic [ADDR_W-1:0]  best_pos;

  // memory ports
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [STAMP_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [STAMP_W-1:0] mem_rdata;

  logic               in_xfer;
  logic [ADDR_W-1:0]  ins_pos;
  logic [CNT_W-1:0]   count_ins;
  logic               issue;
  logic               out_free;
  logic               cfg_wr;

  // Window memory, indexed by age position (position 0 is the oldest)
  tsrw_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (CAPACITY)
  ) u_window (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Handshake and configuration port
  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_FILL_THRESHOLD);
  assign prdata   = (paddr[2] == REG_FILL_THRESHOLD) ?
                    {{(APB_DW-THR_W){1'b0}}, fill_threshold} : '0;

  // Insert position: count never exceeds CAPACITY-1 here, clamp is defensive
  assign ins_pos   = (int'(count) >= CAPACITY) ? ADDR_W'(CAPACITY - 1) : count[ADDR_W-1:0];
  assign count_ins = CNT_W'(ins_pos) + CNT_W'(1);

  // Sweep reads run while the index is inside the held entries
  assign issue     = (idx < count);
  assign mem_raddr = idx[ADDR_W-1:0];

  // Write port: arrival in idle, shift-down during removal
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ins_pos;
    mem_wdata = arriving_timestamp;
    if (state == ST_IDLE) begin
      mem_we = in_xfer;
    end else if (state == ST_SHIFT) begin
      mem_we    = pend_vld;
      mem_waddr = pend_pos - ADDR_W'(1);
      mem_wdata = mem_rdata;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_threshold <= THR_RESET;
    end else if (cfg_wr) begin
      fill_threshold <= pwdata[THR_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      last_released <= '0;
      pend_vld      <= 1'b0;
      idx           <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          pend_vld <= 1'b0;
          idx      <= '0;
          if (in_xfer) begin
            count <= count_ins;
            if (count_ins >= eff_threshold(fill_threshold)) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pend_vld <= issue;
          pend_pos <= idx[ADDR_W-1:0];
          if (issue) begin
            idx <= idx + CNT_W'(1);
          end
          // compare stage: strict less keeps the oldest on ties
          if (pend_vld) begin
            if (pend_pos == '0 || mem_rdata < best_val) begin
              best_val <= mem_rdata;
              best_pos <= pend_pos;
            end
            if (CNT_W'(pend_pos) + CNT_W'(1) == count) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          pend_vld <= 1'b0;
          if (out_free) begin
            last_released <= best_val;
            idx           <= CNT_W'(best_pos) + CNT_W'(1);
            state         <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          pend_vld <= issue;
          pend_pos <= idx[ADDR_W-1:0];
          if (issue) begin
            idx <= idx + CNT_W'(1);
          end
          if (!issue && !pend_vld) begin
            count <= count - CNT_W'(1);
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      released_timestamp <= best_val;
      went_backwards     <= (best_val < last_released);
    end
  end

endmodule

/* sv/tsrw_ram.sv */
// Generic simple dual-port RAM with registered read.
module tsrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tsrw_checker.sv */
// Port-level checks for the reorder window, bound to the top level.
module tsrw_checker
  import tsrw_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [STAMP_W-1:0] released_timestamp,
  input logic               went_backwards
);

  // last released value seen at the output
  logic [STAMP_W-1:0] seen_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_last <= '0;
    end else if (out_valid && !out_stall) begin
      seen_last <= released_timestamp;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(released_timestamp)
                               && $stable(went_backwards))
    else $error("stalled result changed");

  // backwards flag agrees with the previous transfer
  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (went_backwards == (released_timestamp < seen_last)))
    else $error("went_backwards disagrees with previous release");

  // a release never follows an input transfer in the next cycle
  a_no_fast_release: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too soon after input transfer");

  // while the window is being compacted no input is taken
  a_busy_on_release: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_stall)
    else $error("input open while a release is in progress");

endmodule

bind timestamp_reorder_window_core tsrw_checker u_tsrw_checker (.*);

/* sim/tsrw_release_checker.sv */
// Release checker for the timestamp reorder window: predicts releases and compares them.
`timescale 1ns / 1ps

module tsrw_release_checker
  import tsrw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [STAMP_W-1:0] arriving_timestamp,
  // output channel
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [STAMP_W-1:0] released_timestamp,
  input  logic               went_backwards,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  // results for the top
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic               backwards;
  } release_t;

  logic [THR_W-1:0]   fill_thr;
  logic [STAMP_W-1:0] window_q[$];   // held stamps, oldest first
  logic [STAMP_W-1:0] last_out;
  release_t           release_q[$];  // releases still owed by the block
  int                 mismatch_cnt;

  // Threshold as applied: zero acts as one, anything above capacity saturates
  function automatic int release_level(input logic [THR_W-1:0] thr);
    int lvl;
    lvl = int'(thr);
    if (lvl < 1) lvl = 1;
    if (lvl > CAPACITY) lvl = CAPACITY;
    return lvl;
  endfunction

  // Append an arrival; once the window is full enough, release its oldest minimum
  task automatic take_arrival(input logic [STAMP_W-1:0] stamp);
    int       pick;
    int       i;
    release_t rel;
    window_q.push_back(stamp);
    if (window_q.size() >= release_level(fill_thr)) begin
      pick = 0;
      for (i = 1; i < window_q.size(); i++) begin
        // strict compare keeps the oldest of equal stamps
        if (window_q[i] < window_q[pick]) pick = i;
      end
      rel.stamp     = window_q[pick];
      rel.backwards = (window_q[pick] < last_out);
      last_out      = window_q[pick];
      window_q.delete(pick);
      release_q.push_back(rel);
    end
  endtask

  // Watch all three ports at each edge
  always @(posedge clk) begin : watch
    release_t want;
    if (rst) begin
      fill_thr = THR_RESET;
      last_out = '0;
      window_q.delete();
      release_q.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready && paddr[2] == REG_FILL_THRESHOLD) begin
        fill_thr = pwdata[THR_W-1:0];
      end
      // release transfer against the oldest expectation
      if (out_valid && !out_stall) begin
        if (release_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected release: got %h backwards %b",
                     released_timestamp, went_backwards);
          end
        end else begin
          want = release_q.pop_front();
          if (released_timestamp !== want.stamp || went_backwards !== want.backwards) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("release mismatch: expected %h backwards %b, got %h backwards %b",
                       want.stamp, want.backwards, released_timestamp, went_backwards);
            end
          end
        end
      end
      // arrival transfer
      if (in_valid && !in_stall) take_arrival(arriving_timestamp);
    end
    outstanding <= release_q.size();
    mismatches  <= mismatch_cnt;
  end

endmodule

/* sim/timestamp_reorder_window_core_tb.sv */
// Testbench top for the timestamp reorder window: stimulus, idling and verdict.
`timescale 1ns / 1ps

module timestamp_reorder_window_core_tb
  import tsrw_pkg::*;
();

  localparam int   SETTLE_CYCLES = 80;    // longest busy time of one item, with margin
  localparam int   QUIET_LIMIT   = 1000;  // cycles without any transfer
  localparam int   ITEM_TARGET   = 1300;
  localparam logic REG_UNUSED    = 1'b1;  // second register slot, not decoded

  typedef enum int {MIX_RANDOM, MIX_NARROW, MIX_JITTER, MIX_EDGES} stamp_mix_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [STAMP_W-1:0] arriving_timestamp;
  logic               out_valid;
  logic               out_stall;
  logic [STAMP_W-1:0] released_timestamp;
  logic               went_backwards;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  int                 mismatches;
  int                 outstanding;

  bit                 send_gaps  = 1'b1;
  bit                 drain_gaps = 1'b1;
  logic [STAMP_W-1:0] jitter_base;

  // Opening set at the reset threshold: extremes, bit patterns, ties
  logic [STAMP_W-1:0] opening_stamps [20] = '{
    64'hFFFF_FFFF_FFFF_FFFF, 64'h0,                  64'h8000_0000_0000_0000,
    64'h7FFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
    64'd1,                   64'hFFFF_FFFF_FFFF_FFFE, 64'd7,
    64'd7,                   64'd7,                  64'd0,
    64'd1000,                64'd999,                64'hDEAD_BEEF_0123_4567,
    64'h0123_4567_89AB_CDEF, 64'd3,                  64'd2,
    64'd0,                   64'd5
  };
  // After lowering the threshold to one with the window still loaded
  logic [STAMP_W-1:0] lowered_stamps [5] = '{
    64'd4, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9
  };
  // Thresholds for the first random phases: zero, full window, saturation
  logic [THR_W-1:0]   corner_thr [8] = '{6'd0, 6'd32, 6'd63, 6'd2, 6'd33, 6'd31, 6'd18, 6'd1};

  timestamp_reorder_window_core dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .arriving_timestamp (arriving_timestamp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .released_timestamp (released_timestamp),
    .went_backwards     (went_backwards),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  tsrw_release_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .arriving_timestamp (arriving_timestamp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .released_timestamp (released_timestamp),
    .went_backwards     (went_backwards),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Next stamp for the given mix
  function automatic logic [STAMP_W-1:0] next_stamp(input stamp_mix_t mix);
    logic [STAMP_W-1:0] v;
    case (mix)
      MIX_NARROW: v = STAMP_W'($urandom_range(0, 7));
      MIX_JITTER: begin
        // mostly rising stream with late arrivals mixed in
        jitter_base = jitter_base + STAMP_W'($urandom_range(0, 20));
        v = jitter_base - STAMP_W'($urandom_range(0, 40));
      end
      MIX_EDGES: begin
        case ($urandom_range(0, 3))
          0:       v = STAMP_W'($urandom_range(0, 3));
          1:       v = '1 - STAMP_W'($urandom_range(0, 3));
          2:       v = {1'b1, 61'd0, 2'($urandom_range(0, 3))};
          default: v = {1'b0, {61{1'b1}}, 2'($urandom_range(0, 3))};
        endcase
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // One arrival transfer, after a random gap when send_gaps is set
  task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
    int gap;
    gap = send_gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    arriving_timestamp <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending until every expected release has come
  task automatic hold_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Drain, then let the block finish compacting the window after its last release
  task automatic settle();
    hold_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup and access cycle of a register write
  task automatic reg_write(input logic regsel, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: random stall before each release transfer when drain_gaps is set
  initial begin : receiver
    int gap;
    forever begin
      gap = drain_gaps ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // Watchdog: ends the run when no transfer happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    int               sent;
    int               phase;
    int               phase_len;
    int               pause_at;
    int               k;
    logic [THR_W-1:0] thr;
    stamp_mix_t       mix;

    in_valid           <= 1'b0;
    arriving_timestamp <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    rst                <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset threshold: first release after eighteen arrivals
    foreach (opening_stamps[i]) send_stamp(opening_stamps[i]);
    settle();
    // lower to one with the window loaded; undecoded slot must not change it
    reg_write(REG_FILL_THRESHOLD, 32'd1);
    reg_write(REG_UNUSED, 32'h0000_003F);
    foreach (lowered_stamps[i]) send_stamp(lowered_stamps[i]);
    sent  = 25;
    phase = 0;

    // random phases, each with its own threshold, stamp mix and idling
    while (sent < ITEM_TARGET) begin
      settle();
      thr = (phase < 8) ? corner_thr[phase] : THR_W'($urandom_range(0, 63));
      if ($urandom_range(0, 4) == 0) reg_write(REG_UNUSED, $urandom);
      reg_write(REG_FILL_THRESHOLD, ($urandom & 32'hFFFF_FFC0) | APB_DW'(thr));
      mix         = stamp_mix_t'($urandom_range(0, 3));
      send_gaps   = ($urandom_range(0, 3) != 0);
      drain_gaps  = ($urandom_range(0, 3) != 0);
      jitter_base = {$urandom, $urandom};
      phase_len   = $urandom_range(30, 150);
      pause_at    = $urandom_range(0, phase_len - 1);
      for (k = 0; k < phase_len; k++) begin
        if (k == pause_at) hold_for_drain();
        send_stamp(next_stamp(mix));
      end
      sent += phase_len;
      phase++;
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
